@@ sv/capr_pkg.sv @@
`default_nettype none

package capr_pkg;

  // Default sizing of the automaton and of one generation.
  localparam int CELL_COUNT_DEF     = 1409;
  localparam int WORDS_PER_STEP_DEF = 44;

  // Request and result payload widths.
  localparam int WORD_W     = 32;
  localparam int SEED_IDX_W = 6;

  // Request codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

  // Tempering constants.
  localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc60000;
  localparam int TEMPER_U = 11;
  localparam int TEMPER_S = 7;
  localparam int TEMPER_T = 15;
  localparam int TEMPER_L = 18;

  // Control broadcast from the top level to every chunk.
  typedef struct packed {
    logic              step;
    logic [WORD_W-1:0] seed_bits;
  } capr_ctl_t;

endpackage

`default_nettype wire

@@ sv/capr_ifs.sv @@
`default_nettype none

interface capr_in_if;
  import capr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [SEED_IDX_W-1:0] seed_index;
  logic [WORD_W-1:0]     seed_bits;

  modport source (output valid, output cmd, output seed_index, output seed_bits,
                  input ready);
  modport sink   (input valid, input cmd, input seed_index, input seed_bits,
                  output ready);
endinterface

interface capr_out_if;
  import capr_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

@@ sv/capr_chunk.sv @@
`default_nettype none

// One 32-cell slice of the automaton. Bit 31 holds the lowest cell of the
// slice, bit 0 the highest; cells past the end of the automaton stay zero.
module capr_chunk
  import capr_pkg::*;
#(
  parameter bit IS_FIRST   = 1'b0,
  parameter int VALID_BITS = WORD_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire capr_ctl_t         ctl,
  input  wire logic              load_en,
  input  wire logic              left_in,
  input  wire logic              right_in,
  output logic      [WORD_W-1:0] q,
  output logic      [WORD_W-1:0] stepped
);

  localparam logic [WORD_W-1:0] MASK = ~({WORD_W{1'b1}} >> VALID_BITS);

  logic [WORD_W-1:0] cells_r;
  logic [WORD_W-1:0] cells_nxt;
  logic [WORD_W+1:0] ext;

  assign ext = {left_in, cells_r, right_in};

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      // lowest cell of the whole automaton has no self term
      if (IS_FIRST && j == WORD_W - 1) begin
        stepped[j] = ext[j+2] ^ ext[j];
      end else begin
        stepped[j] = ext[j+2] ^ cells_r[j] ^ ext[j];
      end
    end
    stepped = stepped & MASK;
  end

  always_comb begin
    cells_nxt = cells_r;
    if (load_en) begin
      cells_nxt = ctl.seed_bits & MASK;
    end else if (ctl.step) begin
      cells_nxt = stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= '0;
    end else begin
      cells_r <= cells_nxt;
    end
  end

  assign q = cells_r;

endmodule

`default_nettype wire

@@ sv/ca_rule90_150_prng_tempered_top.sv @@
`default_nettype none

// Hybrid rule 90/150 cellular automaton word generator with tempering.
//
// Input channel (in_chan): each request is a load (cmd = 0), which writes
// the 32 seed bits into chunk seed_index, bit 31 into the lowest cell of the
// chunk, or a generate (cmd = 1), which returns one tempered 32-bit word on
// out_chan. A load returns nothing and forces the next generate to advance
// the automaton before reading word 0.
//
// Timing: one request per cycle, sustained while out_chan is not held off.
// A generate's word goes through word select into the first stage register,
// then through tempering into the output register that drives out_chan.
// Every cell updates in parallel, so advancing costs no extra time.
//
// Stalls: while out_chan is held off, the output register keeps the word and
// the first stage keeps one more; in_chan.ready drops only when both are full.
//
// Reset (rst_n low, synchronous): all cells clear, the word counter reads
// exhausted, and both pipeline stages empty.
module ca_rule90_150_prng_tempered_top
  import capr_pkg::*;
#(
  parameter int CELL_COUNT     = CELL_COUNT_DEF,
  parameter int WORDS_PER_STEP = WORDS_PER_STEP_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  capr_in_if.sink    in_chan,
  capr_out_if.source out_chan
);

  localparam int NCHUNK = (CELL_COUNT + WORD_W - 1) / WORD_W;
  localparam int LAST_BITS = CELL_COUNT - WORD_W * (NCHUNK - 1);
  localparam int CW = $clog2(WORDS_PER_STEP + 2);
  localparam logic [CW-1:0] CNT_EXHAUSTED = CW'(WORDS_PER_STEP + 1);
  localparam logic [CW-1:0] CNT_LIMIT     = CW'(WORDS_PER_STEP);

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> TEMPER_U);
    y = y ^ ((y << TEMPER_S) & TEMPER_B);
    y = y ^ ((y << TEMPER_T) & TEMPER_C);
    y = y ^ (y >> TEMPER_L);
    return y;
  endfunction

  // Handshake and request decode.
  logic s1_v_r, s1_v_nxt;
  logic out_v_r;
  logic s2_adv;
  logic in_ready;
  logic acc, gen_acc, load_acc;
  logic need_step;

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [WORD_W-1:0] s1_word_r, s1_word_nxt;
  logic [WORD_W-1:0] out_word_r;
  logic [WORD_W-1:0] word_sel;

  capr_ctl_t ctl;

  logic [WORD_W-1:0] chunk_q    [NCHUNK];
  logic [WORD_W-1:0] chunk_step [NCHUNK];
  logic [NCHUNK-1:0] ld_en;

  assign s2_adv   = !out_v_r || out_chan.ready;
  assign in_ready = !s1_v_r || s2_adv;
  assign in_chan.ready = in_ready;

  assign acc      = in_chan.valid && in_ready;
  assign gen_acc  = acc && (in_chan.cmd == CMD_GEN);
  assign load_acc = acc && (in_chan.cmd == CMD_LOAD);

  // Advance the automaton when the current generation is used up.
  assign need_step = cnt_r >= CNT_LIMIT;

  assign ctl = '{step: gen_acc && need_step, seed_bits: in_chan.seed_bits};

  // Row of chunks; neighbors trade their edge cells every cycle, and the
  // outermost neighbors are the null boundary.
  for (genvar k = 0; k < NCHUNK; k++) begin : g_chunk
    logic left_in, right_in;

    assign ld_en[k] = load_acc && (32'(in_chan.seed_index) == k);

    if (k == 0) begin : g_left_edge
      assign left_in = 1'b0;
    end else begin : g_left_nb
      assign left_in = chunk_q[k-1][0];
    end

    if (k == NCHUNK - 1) begin : g_right_edge
      assign right_in = 1'b0;
    end else begin : g_right_nb
      assign right_in = chunk_q[k+1][WORD_W-1];
    end

    capr_chunk #(
      .IS_FIRST   (k == 0),
      .VALID_BITS ((k == NCHUNK - 1) ? LAST_BITS : WORD_W)
    ) u_chunk (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .load_en  (ld_en[k]),
      .left_in  (left_in),
      .right_in (right_in),
      .q        (chunk_q[k]),
      .stepped  (chunk_step[k])
    );
  end

  // Select the current word; words past the last chunk read as zero.
  always_comb begin
    word_sel = '0;
    for (int k = 0; k < NCHUNK; k++) begin
      if (k < WORDS_PER_STEP && cnt_r == CW'(k)) begin
        word_sel = chunk_q[k];
      end
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    s1_v_nxt    = s1_v_r;
    s1_word_nxt = s1_word_r;
    if (load_acc) begin
      cnt_nxt = CNT_EXHAUSTED;
    end else if (gen_acc) begin
      cnt_nxt = need_step ? CW'(1) : cnt_r + CW'(1);
    end
    if (in_ready) begin
      s1_v_nxt    = gen_acc;
      // take word 0 of the freshly stepped generation when advancing
      s1_word_nxt = need_step ? chunk_step[0] : word_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= CNT_EXHAUSTED;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      s1_v_r <= s1_v_nxt;
      if (s2_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    s1_word_r <= s1_word_nxt;
    if (s2_adv) begin
      out_word_r <= temper(s1_word_r);
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.random_word = out_word_r;

endmodule

`default_nettype wire

@@ sv/capr_chk.sv @@
`default_nettype none

module capr_chk
  import capr_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_cmd,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [WORD_W-1:0] out_word
);

  // A pending word stays offered until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("result word changed while stalled");

  // A new word appears only in response to an accepted generate request.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_cmd == CMD_GEN, 2))
    else $error("result without a matching generate request");

  // With the output free to move, the block always takes a request.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("request held off while output path is free");

endmodule

bind ca_rule90_150_prng_tempered_top capr_chk u_capr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_cmd    (in_chan.cmd),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word  (out_chan.random_word)
);

`default_nettype wire

@@ verif/tb_ca_rule90_150_prng_tempered_top.sv @@
`timescale 1ns / 100ps

// Testbench for the rule 90/150 automaton word generator.
// Drive load and generate requests on in_chan, mirror the automaton in a
// local copy, and check every tempered word on out_chan in order.
module tb_ca_rule90_150_prng_tempered_top;
  import capr_pkg::*;

  localparam int CELLS      = CELL_COUNT_DEF;
  localparam int GEN_WORDS  = WORDS_PER_STEP_DEF;
  localparam int CHUNKS     = (CELLS + WORD_W - 1) / WORD_W;
  localparam int IDLE_PCT   = 17;
  localparam int HOLD_LEN   = 60;
  localparam int STUCK_MAX  = 1000;
  localparam int DRAIN_WAIT = 10;

  // One row of the directed table. Where lit is set, the expected word is
  // typed in; otherwise the automaton mirror supplies it.
  typedef struct packed {
    logic              cmd;
    logic [5:0]        idx;
    logic [WORD_W-1:0] bits;
    logic              lit;
    logic [WORD_W-1:0] lit_word;
  } dir_row_t;

  localparam int DIR_N = 21;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // An all-zero automaton gives zero words, and zero tempers to zero.
    '{CMD_GEN,  6'd0,  32'h0,        1'b1, 32'h0},
    '{CMD_GEN,  6'd0,  32'hFFFFFFFF, 1'b1, 32'h0},
    // Chunks wholly outside the automaton write nothing.
    '{CMD_LOAD, 6'd63, 32'hFFFFFFFF, 1'b0, 32'h0},
    '{CMD_GEN,  6'd63, 32'hFFFFFFFF, 1'b1, 32'h0},
    '{CMD_LOAD, 6'd45, 32'hFFFFFFFF, 1'b0, 32'h0},
    '{CMD_GEN,  6'd0,  32'h0,        1'b1, 32'h0},
    '{CMD_LOAD, 6'd0,  32'h0,        1'b0, 32'h0},
    '{CMD_GEN,  6'd0,  32'h0,        1'b1, 32'h0},
    // Single seed cell at the left boundary.
    '{CMD_LOAD, 6'd0,  32'h80000000, 1'b0, 32'h0},
    '{CMD_GEN,  6'd0,  32'h0,        1'b0, 32'h0},
    '{CMD_GEN,  6'd0,  32'h0,        1'b0, 32'h0},
    // Partial last chunk: only the final, never-output cell is written.
    '{CMD_LOAD, 6'd44, 32'hFFFFFFFF, 1'b0, 32'h0},
    '{CMD_GEN,  6'd0,  32'h0,        1'b0, 32'h0},
    '{CMD_LOAD, 6'd43, 32'h00000001, 1'b0, 32'h0},
    '{CMD_LOAD, 6'd0,  32'hFFFFFFFF, 1'b0, 32'h0},
    '{CMD_LOAD, 6'd22, 32'hFFFFFFFF, 1'b0, 32'h0},
    '{CMD_GEN,  6'd0,  32'h0,        1'b0, 32'h0},
    '{CMD_GEN,  6'd0,  32'h0,        1'b0, 32'h0},
    '{CMD_LOAD, 6'd1,  32'hA5A5A5A5, 1'b0, 32'h0},
    '{CMD_LOAD, 6'd2,  32'h5A5A5A5A, 1'b0, 32'h0},
    '{CMD_GEN,  6'd0,  32'h0,        1'b0, 32'h0}
  };

  logic clk = 1'b0;
  logic rst_n;

  capr_in_if  in_if ();
  capr_out_if out_if ();

  ca_rule90_150_prng_tempered_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Automaton mirror and the words it still owes.
  bit [CELLS-1:0]    ca_cells;
  int unsigned       ca_word_idx;
  logic [WORD_W-1:0] words_due [$];

  int err_count;
  int n_loads, n_loads_outside, n_gens, n_words_checked, n_generations;

  // Handles between the request driver and the result side.
  bit src_idle_en;
  bit sink_idle_en;
  bit hold_req;
  int hold_left;

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("[%0t] MISMATCH %s: got %08h expected %08h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic logic [WORD_W-1:0] temper_word(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] y;
    y = raw;
    y ^= (y >> TEMPER_U);
    y ^= (y << TEMPER_S) & TEMPER_B;
    y ^= (y << TEMPER_T) & TEMPER_C;
    y ^= (y >> TEMPER_L);
    return y;
  endfunction

  // Advance the mirror by one request; return the word a generate yields.
  task automatic mirror_request(input logic cmd, input logic [5:0] idx,
                                input logic [WORD_W-1:0] bits,
                                output bit has_word, output logic [WORD_W-1:0] word);
    bit [CELLS-1:0]    nxt;
    logic [WORD_W-1:0] raw;
    int unsigned       cell_no;
    has_word = 1'b0;
    word     = '0;
    if (cmd == CMD_LOAD) begin
      for (int i = 0; i < WORD_W; i++) begin
        cell_no = idx * WORD_W + i;
        if (cell_no < CELLS) ca_cells[cell_no] = bits[WORD_W-1-i];
      end
      ca_word_idx = GEN_WORDS + 1;
    end else begin
      if (ca_word_idx >= GEN_WORDS) begin
        // Rule 150 everywhere, then drop the self term from cell 0 (rule 90).
        nxt = (ca_cells << 1) ^ ca_cells ^ (ca_cells >> 1);
        nxt[0] = ca_cells[1];
        ca_cells = nxt;
        ca_word_idx = 0;
        n_generations++;
      end
      for (int i = 0; i < WORD_W; i++) begin
        cell_no = ca_word_idx * WORD_W + i;
        raw[WORD_W-1-i] = (cell_no < CELLS) ? ca_cells[cell_no] : 1'b0;
      end
      ca_word_idx++;
      has_word = 1'b1;
      word     = temper_word(raw);
    end
  endtask

  // Offer one request; call at a falling edge, returns at a falling edge.
  task automatic send_req(input logic cmd, input logic [5:0] idx,
                          input logic [WORD_W-1:0] bits,
                          input logic lit, input logic [WORD_W-1:0] lit_word);
    bit                has_word;
    logic [WORD_W-1:0] word;
    while (src_idle_en && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.seed_index <= idx;
    in_if.seed_bits  <= bits;
    // Hold the request until the block takes it.
    do @(posedge clk); while (!in_if.ready);
    mirror_request(cmd, idx, bits, has_word, word);
    if (has_word) begin
      words_due.push_back(lit ? lit_word : word);
      n_gens++;
    end else begin
      n_loads++;
      if (idx >= CHUNKS) n_loads_outside++;
    end
    @(negedge clk);
  endtask

  task automatic send_gen();
    send_req(CMD_GEN, 6'($urandom_range(0, 63)), $urandom(), 1'b0, '0);
  endtask

  task automatic send_load(input logic [5:0] idx);
    send_req(CMD_LOAD, idx, $urandom(), 1'b0, '0);
  endtask

  // Drop valid and wait until every owed word has come back.
  task automatic drain_words();
    in_if.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    out_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_LEN - 1;
        out_if.ready <= 1'b0;
      end else if (sink_idle_en) begin
        out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted word against the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (words_due.size() == 0) begin
        report_mismatch("unexpected word", out_if.random_word, '0);
      end else begin
        if (out_if.random_word !== words_due[0])
          report_mismatch("random_word", out_if.random_word, words_due[0]);
        void'(words_due.pop_front());
        n_words_checked++;
      end
    end
  end

  // End the run if neither channel moves for too long.
  int stuck_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_MAX) begin
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d words owed",
               $realtime, STUCK_MAX, words_due.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int order [$];
    int pick;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_LOAD;
    in_if.seed_index = '0;
    in_if.seed_bits  = '0;
    rst_n            = 1'b0;
    src_idle_en      = 1'b1;
    sink_idle_en     = 1'b1;
    hold_req         = 1'b0;
    err_count        = 0;
    ca_cells         = '0;
    ca_word_idx      = GEN_WORDS + 1;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: boundaries, outside chunks, the unused last cell.
    foreach (DIR_ROWS[r])
      send_req(DIR_ROWS[r].cmd, DIR_ROWS[r].idx, DIR_ROWS[r].bits,
               DIR_ROWS[r].lit, DIR_ROWS[r].lit_word);

    // Run through two full generations so the counter wraps.
    repeat (2 * GEN_WORDS + 2) send_gen();

    // Reseed every chunk in random order, then generate well past a wrap.
    for (int k = 0; k < CHUNKS; k++) order.push_back(k);
    while (order.size() != 0) begin
      pick = $urandom_range(0, order.size() - 1);
      send_load(6'(order[pick]));
      order.delete(pick);
    end
    repeat (100) send_gen();

    // Hold off the result side while requests keep coming, so the block
    // fills and stalls its input.
    src_idle_en = 1'b0;
    hold_req    = 1'b1;
    repeat (30) send_gen();
    src_idle_en = 1'b1;

    // Let everything owed come back before going on.
    drain_words();

    // Mixed requests: mostly generates, loads anywhere in the index range.
    for (int n = 0; n < 200; n++) begin
      if ($urandom_range(0, 99) < 70)
        send_gen();
      else if ($urandom_range(0, 99) < 80)
        send_load(6'($urandom_range(0, CHUNKS - 1)));
      else
        send_load(6'($urandom_range(CHUNKS, 63)));
      if (n % 67 == 66) drain_words();
    end

    // Back-to-back stretch with no idling on either side.
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int n = 0; n < 100; n++) begin
      if ($urandom_range(0, 99) < 85) send_gen();
      else send_load(6'($urandom_range(0, 63)));
    end
    sink_idle_en = 1'b1;

    in_if.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d loads (%0d past the automaton) and %0d generates over %0d",
             n_loads, n_loads_outside, n_gens, n_generations);
    $display("automaton steps; %0d words checked, one long output hold, %0d mismatches.",
             n_words_checked, err_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/capr_pkg.sv
sv/capr_ifs.sv
sv/capr_chunk.sv
sv/ca_rule90_150_prng_tempered_top.sv
sv/capr_chk.sv
verif/tb_ca_rule90_150_prng_tempered_top.sv
